// ===== rtl/bsu_pkg.sv =====
// ============================================================================
// bsu_pkg
// Shared types, constants and codes for the bytecode stack unit.
// ============================================================================
package bsu_pkg;

    localparam int DEPTH       = 64;
    localparam int DATA_W      = 32;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [2:0] FUNC_PUSH = 3'd0;
    localparam logic [2:0] FUNC_PALL = 3'd1;
    localparam logic [2:0] FUNC_PTOP = 3'd2;
    localparam logic [2:0] FUNC_POP  = 3'd3;
    localparam logic [2:0] FUNC_SWAP = 3'd4;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BADARG     = 3'd1;
    localparam logic [2:0] ST_PINT_EMPTY = 3'd2;
    localparam logic [2:0] ST_POP_EMPTY  = 3'd3;
    localparam logic [2:0] ST_SWAP_SHORT = 3'd4;
    localparam logic [2:0] ST_FULL       = 3'd5;
    localparam logic [2:0] ST_HALTED     = 3'd6;

    typedef enum logic [2:0] {
        OP_PUSH,
        OP_PALL,
        OP_PTOP,
        OP_POP,
        OP_SWAP,
        OP_NOP
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_STATUS,
        S_PTOP_DATA,
        S_PALL_DATA,
        S_SWAP_A,
        S_SWAP_B,
        S_SWAP_C
    } back_state_t;

    typedef struct packed {
        logic [2:0]               func;
        logic signed [DATA_W-1:0] push_value;
        logic                     push_arg_ok;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value_out;
        logic                     value_present;
        logic [2:0]               status;
        logic                     last;
    } out_item_t;

    typedef struct packed {
        op_t                      op;
        logic signed [DATA_W-1:0] value;
        logic                     arg_ok;
    } cmd_t;

endpackage

// ===== rtl/bsu_ram.sv =====
// ============================================================================
// bsu_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module bsu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/bsu_front.sv =====
// ============================================================================
// bsu_front
// Accepts input transactions, classifies the opcode and queues commands.
// ============================================================================
module bsu_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  bsu_pkg::in_item_t in_data,
    output logic              cmd_valid,
    input  logic              cmd_ready,
    output bsu_pkg::cmd_t     cmd
);

    bsu_pkg::cmd_t                    slot_reg [bsu_pkg::QUEUE_DEPTH];
    logic [bsu_pkg::QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [bsu_pkg::QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [bsu_pkg::QCNT_W-1:0]       qcnt_reg, qcnt_next;
    bsu_pkg::cmd_t                    cls;
    logic                             push, pop;

    always_comb
    begin
        cls.value  = in_data.push_value;
        cls.arg_ok = in_data.push_arg_ok;
        case (in_data.func)
            bsu_pkg::FUNC_PUSH: cls.op = bsu_pkg::OP_PUSH;
            bsu_pkg::FUNC_PALL: cls.op = bsu_pkg::OP_PALL;
            bsu_pkg::FUNC_PTOP: cls.op = bsu_pkg::OP_PTOP;
            bsu_pkg::FUNC_POP:  cls.op = bsu_pkg::OP_POP;
            bsu_pkg::FUNC_SWAP: cls.op = bsu_pkg::OP_SWAP;
            default:            cls.op = bsu_pkg::OP_NOP;
        endcase
    end

    assign in_ready  = (qcnt_reg != bsu_pkg::QCNT_W'(bsu_pkg::QUEUE_DEPTH));
    assign cmd_valid = (qcnt_reg != '0);
    assign cmd       = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        qcnt_next   = qcnt_reg;
        if (push && !pop)
        begin
            qcnt_next = qcnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            qcnt_next = qcnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            qcnt_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            qcnt_reg   <= qcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= cls;
        end
    end

`ifndef NO_ASSERTIONS
    a_qcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        qcnt_reg <= bsu_pkg::QCNT_W'(bsu_pkg::QUEUE_DEPTH))
        else $error("queue count overflow");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (qcnt_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with empty count");

    a_cmd_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_ready) |=> (cmd_valid && $stable(cmd)))
        else $error("queued command changed while waiting");
`endif

endmodule

// ===== rtl/bsu_back.sv =====
// ============================================================================
// bsu_back
// Executes queued commands against the stack RAM and drives the result
// register.
// ============================================================================
module bsu_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  bsu_pkg::cmd_t      cmd,
    output logic               out_valid,
    input  logic               out_ready,
    output bsu_pkg::out_item_t out_data
);

    bsu_pkg::back_state_t             state_reg, state_next;
    logic [bsu_pkg::CNT_W-1:0]        count_reg, count_next;
    logic                             halted_reg, halted_next;
    logic [bsu_pkg::ADDR_W-1:0]       idx_reg, idx_next;
    logic [2:0]                       status_reg, status_next;
    logic [bsu_pkg::DATA_W-1:0]       tmp_reg, tmp_next;
    logic                             out_valid_reg, out_valid_next;
    bsu_pkg::out_item_t               out_data_reg;

    logic                             can_load, out_load;
    bsu_pkg::out_item_t               out_item;
    logic                             ram_we, ram_re;
    logic [bsu_pkg::ADDR_W-1:0]       ram_waddr, ram_raddr;
    logic [bsu_pkg::DATA_W-1:0]       ram_wdata, ram_rdata;
    logic [bsu_pkg::CNT_W-1:0]        cnt_m1, cnt_m2;
    logic [bsu_pkg::ADDR_W-1:0]       top_addr, sec_addr;
    logic                             is_empty, is_full, is_short;

    bsu_ram #(
        .WIDTH (bsu_pkg::DATA_W),
        .DEPTH (bsu_pkg::DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cnt_m1   = count_reg - bsu_pkg::CNT_W'(1);
    assign cnt_m2   = count_reg - bsu_pkg::CNT_W'(2);
    assign top_addr = cnt_m1[bsu_pkg::ADDR_W-1:0];
    assign sec_addr = cnt_m2[bsu_pkg::ADDR_W-1:0];
    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == bsu_pkg::CNT_W'(bsu_pkg::DEPTH));
    assign is_short = (count_reg < bsu_pkg::CNT_W'(2));
    assign can_load = !out_valid_reg || out_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bsu_pkg::S_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = bsu_pkg::S_STATUS;
                    if (!halted_reg)
                    begin
                        case (cmd.op)
                            bsu_pkg::OP_PALL:
                                if (!is_empty) state_next = bsu_pkg::S_PALL_DATA;
                            bsu_pkg::OP_PTOP:
                                if (!is_empty) state_next = bsu_pkg::S_PTOP_DATA;
                            bsu_pkg::OP_SWAP:
                                if (!is_short) state_next = bsu_pkg::S_SWAP_A;
                            default: ;
                        endcase
                    end
                end
            end
            bsu_pkg::S_STATUS, bsu_pkg::S_PTOP_DATA:
            begin
                if (can_load)
                begin
                    state_next = bsu_pkg::S_IDLE;
                end
            end
            bsu_pkg::S_PALL_DATA:
            begin
                if (can_load && idx_reg == '0)
                begin
                    state_next = bsu_pkg::S_IDLE;
                end
            end
            bsu_pkg::S_SWAP_A: state_next = bsu_pkg::S_SWAP_B;
            bsu_pkg::S_SWAP_B: state_next = bsu_pkg::S_SWAP_C;
            bsu_pkg::S_SWAP_C: state_next = bsu_pkg::S_STATUS;
            default:           state_next = bsu_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        cmd_ready   = 1'b0;
        count_next  = count_reg;
        halted_next = halted_reg;
        idx_next    = idx_reg;
        status_next = status_reg;
        tmp_next    = tmp_reg;
        ram_we      = 1'b0;
        ram_waddr   = count_reg[bsu_pkg::ADDR_W-1:0];
        ram_wdata   = cmd.value;
        ram_re      = 1'b0;
        ram_raddr   = top_addr;
        out_load    = 1'b0;
        out_item    = '{value_out: '0, value_present: 1'b0,
                        status: status_reg, last: 1'b1};
        case (state_reg)
            bsu_pkg::S_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    status_next = bsu_pkg::ST_OK;
                    if (halted_reg)
                    begin
                        status_next = bsu_pkg::ST_HALTED;
                    end
                    else
                    begin
                        case (cmd.op)
                            bsu_pkg::OP_PUSH:
                            begin
                                if (!cmd.arg_ok)
                                begin
                                    status_next = bsu_pkg::ST_BADARG;
                                    halted_next = 1'b1;
                                end
                                else if (is_full)
                                begin
                                    status_next = bsu_pkg::ST_FULL;
                                    halted_next = 1'b1;
                                end
                                else
                                begin
                                    ram_we     = 1'b1;
                                    count_next = count_reg + bsu_pkg::CNT_W'(1);
                                end
                            end
                            bsu_pkg::OP_PALL:
                            begin
                                if (!is_empty)
                                begin
                                    ram_re   = 1'b1;
                                    idx_next = top_addr;
                                end
                            end
                            bsu_pkg::OP_PTOP:
                            begin
                                if (is_empty)
                                begin
                                    status_next = bsu_pkg::ST_PINT_EMPTY;
                                    halted_next = 1'b1;
                                end
                                else
                                begin
                                    ram_re = 1'b1;
                                end
                            end
                            bsu_pkg::OP_POP:
                            begin
                                if (is_empty)
                                begin
                                    status_next = bsu_pkg::ST_POP_EMPTY;
                                    halted_next = 1'b1;
                                end
                                else
                                begin
                                    count_next = cnt_m1;
                                end
                            end
                            bsu_pkg::OP_SWAP:
                            begin
                                if (is_short)
                                begin
                                    status_next = bsu_pkg::ST_SWAP_SHORT;
                                    halted_next = 1'b1;
                                end
                                else
                                begin
                                    ram_re = 1'b1;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            end
            bsu_pkg::S_STATUS:
            begin
                out_load = can_load;
            end
            bsu_pkg::S_PTOP_DATA:
            begin
                out_load = can_load;
                out_item = '{value_out: ram_rdata, value_present: 1'b1,
                             status: bsu_pkg::ST_OK, last: 1'b1};
            end
            bsu_pkg::S_PALL_DATA:
            begin
                out_load = can_load;
                out_item = '{value_out: ram_rdata, value_present: 1'b1,
                             status: bsu_pkg::ST_OK, last: (idx_reg == '0)};
                if (can_load && idx_reg != '0)
                begin
                    idx_next  = idx_reg - 1'b1;
                    ram_re    = 1'b1;
                    ram_raddr = idx_reg - 1'b1;
                end
            end
            bsu_pkg::S_SWAP_A:
            begin
                tmp_next  = ram_rdata;
                ram_re    = 1'b1;
                ram_raddr = sec_addr;
            end
            bsu_pkg::S_SWAP_B:
            begin
                ram_we    = 1'b1;
                ram_waddr = top_addr;
                ram_wdata = ram_rdata;
            end
            bsu_pkg::S_SWAP_C:
            begin
                ram_we      = 1'b1;
                ram_waddr   = sec_addr;
                ram_wdata   = tmp_reg;
                status_next = bsu_pkg::ST_OK;
            end
            default: ;
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bsu_pkg::S_IDLE;
            count_reg     <= '0;
            halted_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            halted_reg    <= halted_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        status_reg <= status_next;
        tmp_reg    <= tmp_next;
        if (out_load)
        begin
            out_data_reg <= out_item;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= bsu_pkg::CNT_W'(bsu_pkg::DEPTH))
        else $error("entry count above depth");

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("halted flag cleared without reset");

    a_pall_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bsu_pkg::S_PALL_DATA) |->
            (bsu_pkg::CNT_W'(idx_reg) < count_reg))
        else $error("print-all index beyond stack top");

    a_halted_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        $past(halted_reg) |-> $stable(count_reg))
        else $error("stack changed while halted");
`endif

endmodule

// ===== rtl/bytecode_stack_unit.sv =====
// ============================================================================
// bytecode_stack_unit
// Bounded LIFO of signed 32-bit values driven by one opcode per transaction.
// ============================================================================
// Usage:
//   in_valid/in_ready/in_data carry one opcode transaction (func, push_value,
//   push_arg_ok). out_valid/out_ready/out_data carry result transactions
//   (value_out, value_present, status, last). last marks the final result of
//   an input transaction.
//   The front stage classifies opcodes into a two-entry command queue; the
//   back stage executes them against a 64x32 RAM with registered read.
//   An accepted command passes the queue slot and back-stage IDLE, then a
//   STATUS or data state loads the result register; swap goes through
//   SWAP_A, SWAP_B and SWAP_C (two RAM reads and two writes through one port
//   each) before STATUS. Print all emits N entries from PALL_DATA, one entry
//   per cycle while the result register can load.
//   Any error sets a sticky halt; afterwards every transaction returns the
//   halted status until reset. Reset empties the stack and clears the halt;
//   RAM contents are not cleared.
//   When out_ready is low the result register holds and the back stage waits;
//   up to two further commands are still accepted into the queue.
// ============================================================================
module bytecode_stack_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  bsu_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output bsu_pkg::out_item_t out_data
);

    logic          cmd_valid;
    logic          cmd_ready;
    bsu_pkg::cmd_t cmd;

    bsu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    bsu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
